@@ src/sbf_pkg.sv @@
`default_nettype none

package sbf_pkg;

  // Default sizing of the skyline store
  localparam int SBF_MAX_COLUMNS = 1024;
  localparam int SBF_HEIGHT_BITS = 20;

  // Fixed field widths on the ports
  localparam int RECT_W_BITS = 11;
  localparam int RECT_H_BITS = 12;
  localparam int CFG_W_BITS  = 11;
  localparam int OUT_X_BITS  = 10;
  localparam int OUT_H_BITS  = 20;

  // Container width after reset
  localparam logic [CFG_W_BITS-1:0] CFG_WIDTH_RESET = 11'd1024;

endpackage

`default_nettype wire

@@ src/skyline_best_fit_strip_packer.sv @@
`default_nettype none

// Skyline best-fit strip packer.
// Command channel: a rectangle (width, height, last-of-job mark) is taken at
// a clock edge where start is high and busy is low. busy stays high until
// the result has been shown and any clearing pass has finished.
// Result channel: result_valid_o is high for exactly one cycle with all result
// fields; the receiver cannot stall, the beat is taken in that cycle.
// Configuration: cfg_we_i writes the container width; write it only while idle.
// Steps per rectangle of width w in an effective width c:
//   a window search over c-w+1 positions, w skyline reads per window, each
//   read in S_RD and compared in S_CMP through the single RAM read port; then
//   S_TOP forms the top height, S_WR writes the window through the RAM write
//   port, and S_DONE shows the result beat. A rectangle that does not fit
//   shows its result in the cycle right after it is taken.
// Reset and the last-of-job mark start a clearing pass over all MAX_COLUMNS
// skyline columns, one column a cycle, during which busy is high; configuration
// writes are still taken then. The search uses two compares: window maximum, best.
module skyline_best_fit_strip_packer
  import sbf_pkg::*;
#(
  parameter int MAX_COLUMNS = SBF_MAX_COLUMNS,
  parameter int HEIGHT_BITS = SBF_HEIGHT_BITS
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [RECT_W_BITS-1:0] rect_width_i,
  input  wire logic [RECT_H_BITS-1:0] rect_height_i,
  input  wire logic                   last_of_job_i,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_W_BITS-1:0]  cfg_wdata_i,
  output logic                        result_valid_o,
  output logic                        placed_o,
  output logic [OUT_X_BITS-1:0]       placed_x_o,
  output logic [OUT_H_BITS-1:0]       base_height_o,
  output logic [OUT_H_BITS-1:0]       top_height_o,
  output logic [OUT_H_BITS-1:0]       total_height_o,
  output logic                        height_saturated_o
);

  localparam int COL_BITS = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CNT_RAW  = $clog2(MAX_COLUMNS + 1);
  localparam int CNT_W    = (CNT_RAW > RECT_W_BITS) ? CNT_RAW : RECT_W_BITS;
  localparam int SUM_W    = ((HEIGHT_BITS > RECT_H_BITS) ? HEIGHT_BITS : RECT_H_BITS) + 1;
  localparam logic [SUM_W-1:0] HMAX =
    {{(SUM_W-HEIGHT_BITS){1'b0}}, {HEIGHT_BITS{1'b1}}};
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_COLUMNS);
  localparam logic [COL_BITS-1:0] LAST_COL = COL_BITS'(MAX_COLUMNS - 1);

  // Sequencer states
  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_TOP  = 3'd4;
  localparam logic [2:0] S_WR   = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  // Control registers
  logic [2:0]             state_q, state_d;
  logic [CFG_W_BITS-1:0]  cfg_q, cfg_d;
  logic [HEIGHT_BITS-1:0] job_q, job_d;
  logic [COL_BITS-1:0]    clr_q, clr_d;
  logic [CNT_W-1:0]       x_q, x_d;
  logic [CNT_W-1:0]       i_q, i_d;

  // Payload registers
  logic [CNT_W-1:0]       w_q, w_d;
  logic [RECT_H_BITS-1:0] h_q, h_d;
  logic                   last_q, last_d;
  logic [CNT_W-1:0]       cw_q, cw_d;
  logic [HEIGHT_BITS-1:0] m_q, m_d;
  logic [HEIGHT_BITS-1:0] best_q, best_d;
  logic [CNT_W-1:0]       bx_q, bx_d;
  logic [HEIGHT_BITS-1:0] top_q, top_d;
  logic                   sat_q, sat_d;
  logic                   res_placed_q, res_placed_d;
  logic [OUT_X_BITS-1:0]  res_x_q, res_x_d;
  logic [OUT_H_BITS-1:0]  res_base_q, res_base_d;
  logic [OUT_H_BITS-1:0]  res_top_q, res_top_d;
  logic [OUT_H_BITS-1:0]  res_total_q, res_total_d;
  logic                   res_sat_q, res_sat_d;

  // RAM hookup
  logic                   ram_we;
  logic [COL_BITS-1:0]    ram_waddr;
  logic [HEIGHT_BITS-1:0] ram_wdata;
  logic [COL_BITS-1:0]    ram_raddr;
  logic [HEIGHT_BITS-1:0] ram_rdata;

  // Datapath helpers
  logic [CNT_W-1:0]       rd_sum;
  logic [CNT_W-1:0]       wr_sum;
  logic [CNT_W-1:0]       in_w;
  logic [CNT_W-1:0]       cfg_ext;
  logic [CNT_W-1:0]       cw_eff;
  logic [HEIGHT_BITS-1:0] m_new;
  logic [SUM_W-1:0]       top_sum;
  logic [HEIGHT_BITS-1:0] job_new;

  assign rd_sum  = x_q + i_q;
  assign wr_sum  = bx_q + i_q;
  assign in_w    = CNT_W'(rect_width_i);
  assign cfg_ext = CNT_W'(cfg_q);
  assign cw_eff  = (cfg_ext > MAX_CNT) ? MAX_CNT : cfg_ext;
  // Compare unit: running window maximum
  assign m_new   = (ram_rdata > m_q) ? ram_rdata : m_q;
  assign top_sum = SUM_W'(best_q) + SUM_W'(h_q);
  assign job_new = (top_q > job_q) ? top_q : job_q;

  sbf_skyline_ram #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Skyline write: clearing sweep or window fill
  always_comb begin
    ram_we    = (state_q == S_CLR) || (state_q == S_WR);
    ram_waddr = (state_q == S_CLR) ? clr_q : wr_sum[COL_BITS-1:0];
    ram_wdata = (state_q == S_CLR) ? '0 : top_q;
    ram_raddr = rd_sum[COL_BITS-1:0];
  end

  // Sequencer
  always_comb begin
    state_d      = state_q;
    cfg_d        = cfg_we_i ? cfg_wdata_i : cfg_q;
    job_d        = job_q;
    clr_d        = clr_q;
    x_d          = x_q;
    i_d          = i_q;
    w_d          = w_q;
    h_d          = h_q;
    last_d       = last_q;
    cw_d         = cw_q;
    m_d          = m_q;
    best_d       = best_q;
    bx_d         = bx_q;
    top_d        = top_q;
    sat_d        = sat_q;
    res_placed_d = res_placed_q;
    res_x_d      = res_x_q;
    res_base_d   = res_base_q;
    res_top_d    = res_top_q;
    res_total_d  = res_total_q;
    res_sat_d    = res_sat_q;

    case (state_q)
      S_CLR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == LAST_COL) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          w_d    = in_w;
          h_d    = rect_height_i;
          last_d = last_of_job_i;
          cw_d   = cw_eff;
          x_d    = '0;
          i_d    = '0;
          m_d    = '0;
          if (rect_width_i == '0 || in_w > cw_eff) begin
            // does not fit: report at once, skyline untouched
            res_placed_d = 1'b0;
            res_x_d      = '0;
            res_base_d   = '0;
            res_top_d    = '0;
            res_total_d  = OUT_H_BITS'(job_q);
            res_sat_d    = 1'b0;
            state_d      = S_DONE;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        if (i_q + 1'b1 == w_q) begin
          // window complete: keep the leftmost lowest one
          if (x_q == '0 || m_new < best_q) begin
            best_d = m_new;
            bx_d   = x_q;
          end
          m_d = '0;
          i_d = '0;
          if (x_q + w_q == cw_q) begin
            state_d = S_TOP;
          end else begin
            x_d     = x_q + 1'b1;
            state_d = S_RD;
          end
        end else begin
          m_d     = m_new;
          i_d     = i_q + 1'b1;
          state_d = S_RD;
        end
      end
      S_TOP: begin
        if (top_sum > HMAX) begin
          top_d = HMAX[HEIGHT_BITS-1:0];
          sat_d = 1'b1;
        end else begin
          top_d = top_sum[HEIGHT_BITS-1:0];
          sat_d = 1'b0;
        end
        i_d     = '0;
        state_d = S_WR;
      end
      S_WR: begin
        i_d = i_q + 1'b1;
        if (i_q + 1'b1 == w_q) begin
          job_d        = job_new;
          res_placed_d = 1'b1;
          res_x_d      = OUT_X_BITS'(bx_q);
          res_base_d   = OUT_H_BITS'(best_q);
          res_top_d    = OUT_H_BITS'(top_q);
          res_total_d  = OUT_H_BITS'(job_new);
          res_sat_d    = sat_q;
          state_d      = S_DONE;
        end
      end
      S_DONE: begin
        if (last_q) begin
          job_d   = '0;
          clr_d   = '0;
          state_d = S_CLR;
        end else begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state with reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      cfg_q   <= CFG_WIDTH_RESET;
      job_q   <= '0;
      clr_q   <= '0;
      x_q     <= '0;
      i_q     <= '0;
    end else begin
      state_q <= state_d;
      cfg_q   <= cfg_d;
      job_q   <= job_d;
      clr_q   <= clr_d;
      x_q     <= x_d;
      i_q     <= i_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    w_q          <= w_d;
    h_q          <= h_d;
    last_q       <= last_d;
    cw_q         <= cw_d;
    m_q          <= m_d;
    best_q       <= best_d;
    bx_q         <= bx_d;
    top_q        <= top_d;
    sat_q        <= sat_d;
    res_placed_q <= res_placed_d;
    res_x_q      <= res_x_d;
    res_base_q   <= res_base_d;
    res_top_q    <= res_top_d;
    res_total_q  <= res_total_d;
    res_sat_q    <= res_sat_d;
  end

  // Outputs
  assign busy               = (state_q != S_IDLE);
  assign result_valid_o     = (state_q == S_DONE);
  assign placed_o           = res_placed_q;
  assign placed_x_o         = res_x_q;
  assign base_height_o      = res_base_q;
  assign top_height_o       = res_top_q;
  assign total_height_o     = res_total_q;
  assign height_saturated_o = res_sat_q;

`ifndef NO_ASSERTIONS
  // a result beat always comes while the block is busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy)
    else $error("result beat while idle");

  // an accepted command makes the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("command accepted but block not busy");

  // an unplaced result has zero position, base and top heights and no saturation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !placed_o) |->
      (placed_x_o == '0 && base_height_o == '0 && top_height_o == '0 &&
       !height_saturated_o))
    else $error("non-placed result with nonzero fields");

  // a result beat lasts exactly one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result beat longer than one cycle");
`endif

endmodule

`default_nettype wire

@@ src/sbf_skyline_ram.sv @@
`default_nettype none

module sbf_skyline_ram
  import sbf_pkg::*;
#(
  parameter int MAX_COLUMNS = SBF_MAX_COLUMNS,
  parameter int HEIGHT_BITS = SBF_HEIGHT_BITS,
  localparam int COL_BITS = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1
) (
  input  wire logic                   clk_i,
  input  wire logic                   we_i,
  input  wire logic [COL_BITS-1:0]    waddr_i,
  input  wire logic [HEIGHT_BITS-1:0] wdata_i,
  input  wire logic [COL_BITS-1:0]    raddr_i,
  output logic      [HEIGHT_BITS-1:0] rdata_o
);

  logic [HEIGHT_BITS-1:0] mem [MAX_COLUMNS];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire
